// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL modules.
// Needs a signal named clock and a signal named reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- hw/rtl/pli_pkg.sv -----
// Shared types and constants of the positional list block.
// No dependencies.
package pli_pkg;

   localparam int VAL_W = 32;
   localparam int POS_W = 6;
   localparam int LEN_W = 6;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_READ   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Outcome of the request checks.
   typedef struct packed {
      status_type status;
      logic       apply;
   } decision_type;

endpackage

// ----- hw/rtl/pli_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/pli_check.sv -----
// Request checks: list full and position range for each request kind.
// Depends on pli_pkg.
module pli_check #(
   parameter int CAPACITY = 32,
   parameter int CNT_W    = 6,
   parameter int CMP_W    = 10
) (
   input  logic [1:0]                  kind,
   input  logic [pli_pkg::POS_W-1:0]   position,
   input  logic [CNT_W-1:0]            count,
   output pli_pkg::decision_type       decision
);

   logic [CMP_W-1:0] pos_w;
   logic [CMP_W-1:0] cnt_w;
   logic             pos_zero;

   assign pos_w    = CMP_W'(position);
   assign cnt_w    = CMP_W'(count);
   assign pos_zero = (position == '0);

   always_comb begin
      decision.status = pli_pkg::STATUS_OK;
      decision.apply  = 1'b1;
      unique case (kind)
         pli_pkg::KIND_INSERT: begin
            // full check ranks before the position check
            if (count == CNT_W'(CAPACITY)) begin
               decision.status = pli_pkg::STATUS_FULL;
            end else if (pos_zero || (pos_w > cnt_w + CMP_W'(1))) begin
               decision.status = pli_pkg::STATUS_RANGE;
            end
         end
         pli_pkg::KIND_DELETE, pli_pkg::KIND_READ: begin
            if (pos_zero || (pos_w > cnt_w)) begin
               decision.status = pli_pkg::STATUS_RANGE;
            end
         end
         default: begin
            decision.status = pli_pkg::STATUS_RANGE;
         end
      endcase
      if (decision.status != pli_pkg::STATUS_OK) begin
         decision.apply = 1'b0;
      end
   end

endmodule

// ----- hw/rtl/positional_list_insert_delete.sv -----
// Channel  | Ports                                      | Direction
// ---------+--------------------------------------------+----------
// request  | req_valid req_stall req_kind req_position  | in
//          | req_value                                  |
// response | rsp_valid rsp_stall rsp_status             | out
//          | rsp_list_length rsp_read_value             |
//
// One request is worked at a time. An error request goes straight to the done state and a
// read passes through ST_READ_CAP; an insert or delete moves each entry between the insert
// or delete point and the tail, reading it in ST_SHIFT_RD and writing it in ST_SHIFT_WR on
// the single-port-pair entry RAM, and an insert then writes its value in ST_PUT. The result
// register loads on the same edge that returns the block to idle.
// Synchronous active-high reset empties the list; the entry RAM is not
// cleared, since only entries below the count are ever read.
// A request is taken while the previous result still waits under rsp_stall;
// the finished result then holds in the done state until the output frees.
// Depends on pli_pkg, pli_check, pli_ram and assert_macros.svh.
`include "assert_macros.svh"

module positional_list_insert_delete #(
   parameter int CAPACITY = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_kind,
   input  logic [pli_pkg::POS_W-1:0]          req_position,
   input  logic signed [pli_pkg::VAL_W-1:0]   req_value,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [pli_pkg::LEN_W-1:0]          rsp_list_length,
   output logic signed [pli_pkg::VAL_W-1:0]   rsp_read_value
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   // wide enough for count plus one and for any position
   localparam int CMP_W = ((CNT_W > pli_pkg::POS_W) ? CNT_W : pli_pkg::POS_W) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT,
      ST_READ_CAP,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [IDX_W-1:0]               ptr_ff, ptr_in;
   logic [IDX_W-1:0]               end_ff, end_in;
   logic                           is_ins_ff, is_ins_in;
   logic [pli_pkg::VAL_W-1:0]      val_ff, val_in;
   pli_pkg::status_type            status_ff, status_in;
   logic [pli_pkg::VAL_W-1:0]      rd_ff, rd_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   pli_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [pli_pkg::LEN_W-1:0]      rsp_len_ff, rsp_len_in;
   logic [pli_pkg::VAL_W-1:0]      rsp_rd_ff, rsp_rd_in;

   pli_pkg::decision_type          decision;
   logic                           req_xfer;
   logic                           out_free;
   logic [CMP_W-1:0]               pos_w;
   logic [CMP_W-1:0]               cnt_w;
   logic [CMP_W-1:0]               idx_w;
   logic [CMP_W-1:0]               cnt_m1_w;
   logic [IDX_W-1:0]               req_idx;
   logic [IDX_W-1:0]               cnt_idx;
   logic [IDX_W-1:0]               cnt_m1_idx;
   logic [IDX_W-1:0]               ptr_next;

   logic                           ram_we;
   logic [IDX_W-1:0]               ram_waddr;
   logic [pli_pkg::VAL_W-1:0]      ram_wdata;
   logic [IDX_W-1:0]               ram_raddr;
   logic [pli_pkg::VAL_W-1:0]      ram_rdata;

   pli_check #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W),
      .CMP_W    (CMP_W)
   ) u_check (
      .kind     (req_kind),
      .position (req_position),
      .count    (cnt_ff),
      .decision (decision)
   );

   pli_ram #(
      .WIDTH (pli_pkg::VAL_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Take a request whenever no other is in progress.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // 0-based index arithmetic, truncated to the RAM address width.
   assign pos_w      = CMP_W'(req_position);
   assign cnt_w      = CMP_W'(cnt_ff);
   assign idx_w      = pos_w - CMP_W'(1);
   assign cnt_m1_w   = cnt_w - CMP_W'(1);
   assign req_idx    = idx_w[IDX_W-1:0];
   assign cnt_idx    = cnt_w[IDX_W-1:0];
   assign cnt_m1_idx = cnt_m1_w[IDX_W-1:0];

   // Inserts walk down from the old tail, deletes walk up toward it.
   assign ptr_next = is_ins_ff ? (ptr_ff - IDX_W'(1)) : (ptr_ff + IDX_W'(1));

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ptr_ff;
      ram_wdata = ram_rdata;
      ram_raddr = ptr_next;
      if (state_ff == ST_IDLE) begin
         // read requests fetch their entry right at transfer
         ram_raddr = req_idx;
      end
      if (state_ff == ST_SHIFT_WR) begin
         ram_we = 1'b1;
      end else if (state_ff == ST_PUT) begin
         ram_we    = 1'b1;
         ram_waddr = end_ff;
         ram_wdata = val_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      is_ins_in     = is_ins_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      rd_in         = rd_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_rd_in     = rsp_rd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               status_in = decision.status;
               rd_in     = '0;
               val_in    = req_value;
               is_ins_in = (req_kind == pli_pkg::KIND_INSERT);
               state_in  = ST_DONE;
               if (decision.apply) begin
                  case (req_kind)
                     pli_pkg::KIND_INSERT: begin
                        // shift from the old tail down to the insert point
                        cnt_in = cnt_ff + CNT_W'(1);
                        ptr_in = cnt_idx;
                        end_in = req_idx;
                        state_in = (cnt_idx == req_idx) ? ST_PUT : ST_SHIFT_RD;
                     end
                     pli_pkg::KIND_DELETE: begin
                        // close the gap up to the new tail
                        cnt_in = cnt_ff - CNT_W'(1);
                        ptr_in = req_idx;
                        end_in = cnt_m1_idx;
                        state_in = (req_idx == cnt_m1_idx) ? ST_DONE : ST_SHIFT_RD;
                     end
                     default: begin
                        state_in = ST_READ_CAP;
                     end
                  endcase
               end
            end
         end
         ST_SHIFT_RD: begin
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            ptr_in = ptr_next;
            if (ptr_next == end_ff) begin
               state_in = is_ins_ff ? ST_PUT : ST_DONE;
            end else begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_PUT: begin
            state_in = ST_DONE;
         end
         ST_READ_CAP: begin
            rd_in    = ram_rdata;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_len_in    = cnt_w[pli_pkg::LEN_W-1:0];
               rsp_rd_in     = rd_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      end_ff        <= end_in;
      is_ins_ff     <= is_ins_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      rd_ff         <= rd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_rd_ff     <= rsp_rd_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_list_length = rsp_len_ff;
   assign rsp_read_value  = rsp_rd_ff;

   `ASSERT_CLK(a_xfer_leaves_idle, req_xfer |=> (state_ff != ST_IDLE), "transfer did not start work")
   `ASSERT_CLK(a_count_only_on_xfer, !req_xfer |=> $stable(cnt_ff), "count moved without a request")
   `ASSERT_CLK(a_rsp_from_done, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE), "response raised outside done")
   `ASSERT_CLK(a_count_bound, cnt_ff <= CNT_W'(CAPACITY), "count above capacity")

endmodule

// ----- test/tb_positional_list_insert_delete.sv -----
// Self-checking testbench for positional_list_insert_delete: insert, delete and read requests
// are checked against a built-in list predictor, with random idling on both channels.
// Depends on pli_pkg and the positional_list_insert_delete RTL.
module tb_positional_list_insert_delete;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LIST_CAP     = 32;
   localparam int          RANDOM_ITEMS = 600;
   localparam int          SETTLE_LIMIT = 100;
   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          IDLE_PCT     = 31;
   // the request kind that the package leaves unnamed; the block must reject it
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  position;
      logic [31:0] value;
      logic        fixed;        // expected result given in the row itself
      logic [1:0]  status;
      logic [5:0]  length;
      logic [31:0] read_value;
   } directed_row_type;

   typedef struct {
      pli_pkg::status_type status;
      logic [5:0]          length;
      logic [31:0]         read_value;
   } list_result_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [1:0]                   req_kind;
   logic [pli_pkg::POS_W-1:0]    req_position;
   logic signed [31:0]           req_value;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [1:0]                   rsp_status;
   logic [pli_pkg::LEN_W-1:0]    rsp_list_length;
   logic signed [31:0]           rsp_read_value;

   // predictor state: the list as the block should hold it
   logic [31:0]         list_entries [LIST_CAP];
   int                  list_count;
   list_result_type     pending_results [$];

   int                  error_count;
   int                  cycle_count;
   logic                steady_run;     // no idling on either side while set
   directed_row_type    directed_rows [0:23];

   positional_list_insert_delete #(.CAPACITY(LIST_CAP)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_list_length (rsp_list_length),
      .rsp_read_value  (rsp_read_value)
   );

   // 2 ns clock, high then low
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one request to the predicted list and return the result it should give.
   // A full list wins over a bad position on insert.
   function automatic list_result_type list_apply(input logic [1:0] kind,
                                                  input logic [5:0] position,
                                                  input logic [31:0] value);
      list_result_type res;
      int              p;
      int              i;
      res.status     = pli_pkg::STATUS_OK;
      res.read_value = '0;
      p              = position;
      case (kind)
         pli_pkg::KIND_INSERT: begin
            if (list_count >= LIST_CAP) begin
               res.status = pli_pkg::STATUS_FULL;
            end else if (p == 0 || p > list_count + 1) begin
               res.status = pli_pkg::STATUS_RANGE;
            end else begin
               for (i = list_count; i > p - 1; i--) list_entries[i] = list_entries[i - 1];
               list_entries[p - 1] = value;
               list_count++;
            end
         end
         pli_pkg::KIND_DELETE: begin
            if (p == 0 || p > list_count) begin
               res.status = pli_pkg::STATUS_RANGE;
            end else begin
               for (i = p - 1; i + 1 < list_count; i++) list_entries[i] = list_entries[i + 1];
               list_count--;
            end
         end
         pli_pkg::KIND_READ: begin
            if (p == 0 || p > list_count) res.status = pli_pkg::STATUS_RANGE;
            else res.read_value = list_entries[p - 1];
         end
         default: res.status = pli_pkg::STATUS_RANGE;
      endcase
      res.length = 6'(list_count);
      return res;
   endfunction

   // Present one request at a falling edge after random idle cycles, hold it until the
   // transfer, then record what it should produce. Called at or after a rising edge.
   task automatic issue_request(input logic [1:0] kind, input logic [5:0] position,
                                input logic [31:0] value, input logic fixed,
                                input list_result_type typed);
      list_result_type predicted;
      @(negedge clock);
      while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_position <= position;
      req_value    <= value;
      // hold the payload until a rising edge sees no stall
      do @(posedge clock); while (req_stall);
      predicted = list_apply(kind, position, value);
      pending_results.push_back(fixed ? typed : predicted);
   endtask

   // Drop valid and hold off until every outstanding result has come back.
   task automatic drain_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Response side: stall at random on about a third of the cycles.
   always @(negedge clock) begin
      rsp_stall <= !steady_run && ($urandom_range(99) < IDLE_PCT);
   end

   // Compare each result transfer with the oldest expectation, field by field.
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected: status %0d length %0d value %0d",
                     $time, rsp_status, rsp_list_length, rsp_read_value);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_list_length !== want.length) begin
               $display("%0t: list_length expected %0d actual %0d",
                        $time, want.length, rsp_list_length);
               error_count++;
            end
            if (rsp_read_value !== want.read_value) begin
               $display("%0t: read_value expected %0d actual %0d",
                        $time, $signed(want.read_value), rsp_read_value);
               error_count++;
            end
         end
      end
   end

   // Watchdog: the slowest legal run is far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      list_result_type typed;
      list_result_type unused_typed;
      int              segment_pct [12];
      int              insert_pct;
      int              pick;
      logic [1:0]      kind;
      logic [5:0]      position;
      logic [31:0]     value;

      // drive every input to a known value before the first edge
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_kind     = pli_pkg::KIND_READ;
      req_position = '0;
      req_value    = '0;
      rsp_stall    = 1'b0;
      steady_run   = 1'b0;
      error_count  = 0;
      cycle_count  = 0;
      list_count   = 0;
      unused_typed = '{pli_pkg::STATUS_OK, '0, '0};

      // Directed rows: empty-list errors, extreme values, append at the end, out-of-range
      // positions up to 63, the unused kind, then deletes back down to an empty list.
      directed_rows = '{
         '{pli_pkg::KIND_READ,   6'd1,  32'h0,        1'b1, pli_pkg::STATUS_RANGE, 6'd0, 32'h0},
         '{pli_pkg::KIND_DELETE, 6'd1,  32'h0,        1'b1, pli_pkg::STATUS_RANGE, 6'd0, 32'h0},
         '{pli_pkg::KIND_INSERT, 6'd0,  32'h1234,     1'b1, pli_pkg::STATUS_RANGE, 6'd0, 32'h0},
         '{pli_pkg::KIND_INSERT, 6'd2,  32'h1234,     1'b1, pli_pkg::STATUS_RANGE, 6'd0, 32'h0},
         '{KIND_UNUSED,          6'd1,  32'h0,        1'b1, pli_pkg::STATUS_RANGE, 6'd0, 32'h0},
         '{pli_pkg::KIND_INSERT, 6'd1,  32'h7FFFFFFF, 1'b1, pli_pkg::STATUS_OK,    6'd1, 32'h0},
         '{pli_pkg::KIND_INSERT, 6'd1,  32'h80000000, 1'b1, pli_pkg::STATUS_OK,    6'd2, 32'h0},
         '{pli_pkg::KIND_READ,   6'd1,  32'h0,        1'b1, pli_pkg::STATUS_OK,    6'd2,
           32'h80000000},
         '{pli_pkg::KIND_READ,   6'd2,  32'h0,        1'b1, pli_pkg::STATUS_OK,    6'd2,
           32'h7FFFFFFF},
         '{pli_pkg::KIND_READ,   6'd3,  32'h0,        1'b1, pli_pkg::STATUS_RANGE, 6'd2, 32'h0},
         '{pli_pkg::KIND_INSERT, 6'd3,  32'hFFFFFFFF, 1'b1, pli_pkg::STATUS_OK,    6'd3, 32'h0},
         '{pli_pkg::KIND_INSERT, 6'd2,  32'h5A5A5A5A, 1'b0, pli_pkg::STATUS_OK,    6'd0, 32'h0},
         '{pli_pkg::KIND_DELETE, 6'd63, 32'h0,        1'b1, pli_pkg::STATUS_RANGE, 6'd4, 32'h0},
         '{pli_pkg::KIND_READ,   6'd63, 32'h0,        1'b1, pli_pkg::STATUS_RANGE, 6'd4, 32'h0},
         '{pli_pkg::KIND_INSERT, 6'd63, 32'hA5A5A5A5, 1'b1, pli_pkg::STATUS_RANGE, 6'd4, 32'h0},
         '{KIND_UNUSED,          6'd63, 32'hFFFFFFFF, 1'b1, pli_pkg::STATUS_RANGE, 6'd4, 32'h0},
         '{pli_pkg::KIND_READ,   6'd3,  32'h0,        1'b0, pli_pkg::STATUS_OK,    6'd0, 32'h0},
         '{pli_pkg::KIND_DELETE, 6'd4,  32'h0,        1'b0, pli_pkg::STATUS_OK,    6'd0, 32'h0},
         '{pli_pkg::KIND_DELETE, 6'd1,  32'h0,        1'b0, pli_pkg::STATUS_OK,    6'd0, 32'h0},
         '{pli_pkg::KIND_READ,   6'd1,  32'h0,        1'b0, pli_pkg::STATUS_OK,    6'd0, 32'h0},
         '{pli_pkg::KIND_READ,   6'd2,  32'h0,        1'b0, pli_pkg::STATUS_OK,    6'd0, 32'h0},
         '{pli_pkg::KIND_DELETE, 6'd2,  32'h0,        1'b0, pli_pkg::STATUS_OK,    6'd0, 32'h0},
         '{pli_pkg::KIND_DELETE, 6'd1,  32'h0,        1'b0, pli_pkg::STATUS_OK,    6'd0, 32'h0},
         '{pli_pkg::KIND_READ,   6'd1,  32'h0,        1'b1, pli_pkg::STATUS_RANGE, 6'd0, 32'h0}
      };

      // insert share per random segment: swing the length between empty and full
      segment_pct = '{90, 70, 20, 55, 95, 15, 50, 85, 10, 60, 40, 90};

      // hold reset, then release it at a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         typed.status     = pli_pkg::status_type'(directed_rows[r].status);
         typed.length     = directed_rows[r].length;
         typed.read_value = directed_rows[r].read_value;
         issue_request(directed_rows[r].kind, directed_rows[r].position,
                       directed_rows[r].value, directed_rows[r].fixed, typed);
      end

      // pause the sender until the directed results are all back
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         insert_pct = segment_pct[(n / 50) % 12];
         // a long stretch with no idling on either channel
         steady_run = (n >= 300 && n < 420);

         // pick the kind: mostly the segment's mix, now and then the unused kind
         pick = $urandom_range(99);
         if (pick < 3) kind = KIND_UNUSED;
         else if ($urandom_range(99) < insert_pct) kind = pli_pkg::KIND_INSERT;
         else if ($urandom_range(1) == 0) kind = pli_pkg::KIND_DELETE;
         else kind = pli_pkg::KIND_READ;

         // positions mostly inside the list, the rest anywhere in the field
         if ($urandom_range(99) < 15) position = 6'($urandom_range(63));
         else if (kind == pli_pkg::KIND_INSERT) position = 6'($urandom_range(list_count + 1, 1));
         else if (list_count > 0) position = 6'($urandom_range(list_count, 1));
         else position = 6'($urandom_range(63));

         // values: random bits, sometimes the extremes
         case ($urandom_range(19))
            0:       value = 32'h80000000;
            1:       value = 32'h7FFFFFFF;
            2:       value = 32'hFFFFFFFF;
            3:       value = 32'h0;
            default: value = $urandom;
         endcase

         issue_request(kind, position, value, 1'b0, unused_typed);

         // hold off now and then until the block has caught up
         if (n % 100 == 99) drain_results();
      end

      // wait out the last results, then allow for any stray late transfer
      drain_results();
      repeat (SETTLE_LIMIT) @(posedge clock);
      @(negedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- positional_list_insert_delete.f -----
+incdir+hw/rtl
hw/rtl/pli_pkg.sv
hw/rtl/pli_ram.sv
hw/rtl/pli_check.sv
hw/rtl/positional_list_insert_delete.sv
test/tb_positional_list_insert_delete.sv
